>>> rtl/cbez_pkg.sv
// cubic bezier point evaluator: shared constants, widths, register indexes
// and the curve parameter clamp; no dependencies
package cbez_pkg;

   localparam int SURFACE_WIDTH   = 1024;
   localparam int SURFACE_HEIGHT  = 1024;
   localparam int PARAM_FRAC_BITS = 16;

   localparam int NUM_REGS  = 8;
   localparam int CSR_IDX_W = $clog2(NUM_REGS);
   localparam int COORD_W   = 10;
   localparam int PARAM_W   = 16;
   localparam int NUM_LANES = 2;
   localparam int NUM_STG   = 5;

   localparam int T_W     = PARAM_FRAC_BITS;
   localparam int U_W     = PARAM_FRAC_BITS + 1;
   localparam int TRI_W   = COORD_W + 2;
   localparam int A_W     = COORD_W + 2 + PARAM_FRAC_BITS;
   localparam int AU_W    = A_W + U_W;
   localparam int A1_W    = AU_W - PARAM_FRAC_BITS;
   localparam int HI_W    = AU_W;
   localparam int LO_W    = 2 * PARAM_FRAC_BITS + 2;
   localparam int CMP_W   = COORD_W + 1;
   localparam int EXT_W   = ((PARAM_W > T_W) ? PARAM_W : T_W) + 1;
   localparam int T_ONE   = 2 ** PARAM_FRAC_BITS;
   localparam int T_MAX   = T_ONE - 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CTRL0_X = 3'd0,
      REG_CTRL0_Y = 3'd1,
      REG_CTRL1_X = 3'd2,
      REG_CTRL1_Y = 3'd3,
      REG_CTRL2_X = 3'd4,
      REG_CTRL2_Y = 3'd5,
      REG_CTRL3_X = 3'd6,
      REG_CTRL3_Y = 3'd7
   } reg_idx_type;

   // parameter at or above one saturates just below one
   function automatic logic [T_W-1:0] clamp_param(input logic [PARAM_W-1:0] p);
      logic [EXT_W-1:0] pe;
      pe = EXT_W'(p);
      if (pe > EXT_W'(T_MAX)) begin
         return T_W'(T_MAX);
      end
      return pe[T_W-1:0];
   endfunction

endpackage

>>> rtl/cbez_if.sv
// cubic bezier point evaluator: request and response channel interfaces
// depends on cbez_pkg for the field widths
interface cbez_req_if;
   import cbez_pkg::*;

   logic               valid;
   logic               ready;
   logic [PARAM_W-1:0] curve_param;

   modport source (output valid, output curve_param, input ready);
   modport sink   (input valid, input curve_param, output ready);
endinterface

interface cbez_rsp_if;
   import cbez_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;
   logic               inside_res;

   modport source (output valid, output pixel_x, output pixel_y, output inside_res,
                   input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input inside_res,
                   output ready);
endinterface

>>> rtl/cubic_bezier_point_evaluator.sv
// cubic bezier point evaluator: top level, five-stage multiply pipeline
// depends on cbez_pkg and the channel interfaces in cbez_if.sv
//
// Usage: write the four control points through the csr_ port (index 0..7 is
// ctrl0_x, ctrl0_y, ... ctrl3_y, ten bits each) while no transaction is in
// flight. Each request transaction on req_ch carries a curve parameter t in
// unsigned Q0.16; the block answers with exactly one response transaction
// on rsp_ch holding the truncated pixel column and row and a flag set when
// the point lies within the surface.
// Path: a request passes the t1/u1, a2/b2, au3/bt3, hi4/lo4 and pix
// registers in that order before its response is valid on rsp_ch.
// Throughput: one transaction per cycle unless rsp_ch stalls; the pipeline
// holds up to five in flight, one per stage, the multiplier stages setting the depth.
// Stall: when rsp_ch.ready is low and a response waits, every stage holds
// and req_ch.ready drops in the same cycle; nothing is lost or repeated.
// Reset (synchronous, active high): stage valid bits and all control points
// clear to zero.
module cubic_bezier_point_evaluator (
   input  logic                           clock,
   input  logic                           reset,
   cbez_req_if.sink                       req_ch,
   cbez_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [cbez_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cbez_pkg::COORD_W-1:0]   csr_wdata
);
   import cbez_pkg::*;

   logic [COORD_W-1:0] ctrl_ff [NUM_REGS];
   logic [NUM_STG-1:0] stg_v_ff, stg_v_in;
   logic               adv;

   logic [COORD_W-1:0] p0 [NUM_LANES];
   logic [COORD_W-1:0] p1 [NUM_LANES];
   logic [COORD_W-1:0] p2 [NUM_LANES];
   logic [COORD_W-1:0] p3 [NUM_LANES];
   logic [TRI_W-1:0]   tri_p1 [NUM_LANES];
   logic [TRI_W-1:0]   tri_p2 [NUM_LANES];

   logic [T_W-1:0]  t1_ff, t1_in, t2_ff, t3_ff;
   logic [U_W-1:0]  u1_ff, u1_in, u2_ff, u3_ff;
   logic [A_W-1:0]  a2_ff [NUM_LANES];
   logic [A_W-1:0]  a2_in [NUM_LANES];
   logic [A_W-1:0]  b2_ff [NUM_LANES];
   logic [A_W-1:0]  b2_in [NUM_LANES];
   logic [AU_W-1:0] au3_ff [NUM_LANES];
   logic [AU_W-1:0] au3_in [NUM_LANES];
   logic [AU_W-1:0] bt3_ff [NUM_LANES];
   logic [AU_W-1:0] bt3_in [NUM_LANES];
   logic [HI_W-1:0] hi4_ff [NUM_LANES];
   logic [HI_W-1:0] hi4_in [NUM_LANES];
   logic [LO_W-1:0] lo4_ff [NUM_LANES];
   logic [LO_W-1:0] lo4_in [NUM_LANES];
   logic [HI_W-1:0] m5 [NUM_LANES];
   logic [COORD_W-1:0] pix_ff [NUM_LANES];
   logic [COORD_W-1:0] pix_in [NUM_LANES];
   logic               inside_ff, inside_in;

   // whole pipeline moves unless a finished response is held
   assign adv          = !stg_v_ff[NUM_STG-1] || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign stg_v_in     = {stg_v_ff[NUM_STG-2:0], req_ch.valid};

   // control point lanes: lane 0 is x, lane 1 is y
   always_comb begin
      p0[0] = ctrl_ff[REG_CTRL0_X];
      p1[0] = ctrl_ff[REG_CTRL1_X];
      p2[0] = ctrl_ff[REG_CTRL2_X];
      p3[0] = ctrl_ff[REG_CTRL3_X];
      p0[1] = ctrl_ff[REG_CTRL0_Y];
      p1[1] = ctrl_ff[REG_CTRL1_Y];
      p2[1] = ctrl_ff[REG_CTRL2_Y];
      p3[1] = ctrl_ff[REG_CTRL3_Y];
   end

   always_comb begin
      t1_in = clamp_param(req_ch.curve_param);
      u1_in = U_W'(T_ONE) - U_W'(t1_in);
      for (int l = 0; l < NUM_LANES; l++) begin
         tri_p1[l] = TRI_W'({p1[l], 1'b0}) + TRI_W'(p1[l]);
         tri_p2[l] = TRI_W'({p2[l], 1'b0}) + TRI_W'(p2[l]);
         // a = p0 u + 3 p1 t, b = 3 p2 u + p3 t
         a2_in[l]  = A_W'(p0[l]) * A_W'(u1_ff) + A_W'(tri_p1[l]) * A_W'(t1_ff);
         b2_in[l]  = A_W'(tri_p2[l]) * A_W'(u1_ff) + A_W'(p3[l]) * A_W'(t1_ff);
         au3_in[l] = AU_W'(a2_ff[l]) * AU_W'(u2_ff);
         bt3_in[l] = AU_W'(b2_ff[l]) * AU_W'(t2_ff);
         // split into high and fraction parts before the last multiply
         hi4_in[l] = HI_W'(au3_ff[l][AU_W-1:PARAM_FRAC_BITS]) * HI_W'(u3_ff)
                   + HI_W'(bt3_ff[l][AU_W-1:PARAM_FRAC_BITS]) * HI_W'(t3_ff);
         lo4_in[l] = LO_W'(au3_ff[l][PARAM_FRAC_BITS-1:0]) * LO_W'(u3_ff)
                   + LO_W'(bt3_ff[l][PARAM_FRAC_BITS-1:0]) * LO_W'(t3_ff);
         m5[l]     = hi4_ff[l] + HI_W'(lo4_ff[l] >> PARAM_FRAC_BITS);
         pix_in[l] = m5[l][2*PARAM_FRAC_BITS +: COORD_W];
      end
      inside_in = ({1'b0, pix_in[0]} < CMP_W'(SURFACE_WIDTH))
               && ({1'b0, pix_in[1]} < CMP_W'(SURFACE_HEIGHT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_v_ff <= '0;
         for (int r = 0; r < NUM_REGS; r++) begin
            ctrl_ff[r] <= '0;
         end
      end else begin
         if (csr_we) begin
            ctrl_ff[csr_index] <= csr_wdata;
         end
         if (adv) begin
            stg_v_ff <= stg_v_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff     <= t1_in;
         u1_ff     <= u1_in;
         t2_ff     <= t1_ff;
         u2_ff     <= u1_ff;
         t3_ff     <= t2_ff;
         u3_ff     <= u2_ff;
         a2_ff     <= a2_in;
         b2_ff     <= b2_in;
         au3_ff    <= au3_in;
         bt3_ff    <= bt3_in;
         hi4_ff    <= hi4_in;
         lo4_ff    <= lo4_in;
         pix_ff    <= pix_in;
         inside_ff <= inside_in;
      end
   end

   assign rsp_ch.valid      = stg_v_ff[NUM_STG-1];
   assign rsp_ch.pixel_x    = pix_ff[0];
   assign rsp_ch.pixel_y    = pix_ff[1];
   assign rsp_ch.inside_res = inside_ff;

   // a moving first stage hands its transaction to the second one
   a_stage_moves : assert property (@(posedge clock) disable iff (reset)
      adv && stg_v_ff[0] |=> stg_v_ff[1])
      else $error("transaction dropped between first and second stage");

   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> stg_v_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(stg_v_ff))
      else $error("pipeline moved while the response was stalled");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_ch.valid && stg_v_ff == '0)
      else $error("pipeline not empty after reset");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// testbench for the cubic bezier point evaluator: drives curve parameters under
// several control point sets and checks every pixel against an exact predictor
// depends on cbez_pkg, cbez_if.sv and the top level in rtl
module tb;
   import cbez_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 80;
   localparam int RAND_SETS   = 6;
   localparam int HALF_SET    = 75;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               in_surface;
   } pixel_type;

   typedef logic [NUM_REGS-1:0][COORD_W-1:0] curve_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0]   csr_wdata;

   cbez_req_if req_ch ();
   cbez_rsp_if rsp_ch ();

   cubic_bezier_point_evaluator dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [COORD_W-1:0]  ctrl_pt [NUM_REGS];
   logic [PARAM_W-1:0]  param_queue [$];
   pixel_type           pixel_queue [$];

   int mismatch_count = 0;
   int params_sent    = 0;
   int pixels_checked = 0;
   int curve_sets     = 0;
   int cycle_count    = 0;
   int send_gap       = 0;
   int send_burst     = 0;
   int hold_asks      = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int stall_pos      = 0;
   logic [15:0] stall_pat;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // exact floor of the bernstein sum for both coordinates
   function automatic pixel_type bezier_pixel(input logic [PARAM_W-1:0] param);
      longint unsigned t, u, w0, w1, w2, w3, sx, sy;
      pixel_type p;
      t  = (param > T_MAX) ? T_MAX : param;
      u  = T_ONE - t;
      w0 = u * u * u;
      w1 = 3 * t * u * u;
      w2 = 3 * t * t * u;
      w3 = t * t * t;
      sx = ctrl_pt[REG_CTRL0_X] * w0 + ctrl_pt[REG_CTRL1_X] * w1
         + ctrl_pt[REG_CTRL2_X] * w2 + ctrl_pt[REG_CTRL3_X] * w3;
      sy = ctrl_pt[REG_CTRL0_Y] * w0 + ctrl_pt[REG_CTRL1_Y] * w1
         + ctrl_pt[REG_CTRL2_Y] * w2 + ctrl_pt[REG_CTRL3_Y] * w3;
      sx = sx >> (3 * PARAM_FRAC_BITS);
      sy = sy >> (3 * PARAM_FRAC_BITS);
      p.x = sx[COORD_W-1:0];
      p.y = sy[COORD_W-1:0];
      p.in_surface = (sx < SURFACE_WIDTH) && (sy < SURFACE_HEIGHT);
      return p;
   endfunction

   function automatic logic [PARAM_W-1:0] rand_param();
      case ($urandom_range(0, 3))
         0: begin
            return PARAM_W'($urandom_range(0, 255));
         end
         1: begin
            return PARAM_W'($urandom_range(65280, 65535));
         end
         default: begin
            return PARAM_W'($urandom);
         end
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord(input bit edgy);
      if (edgy) begin
         case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return COORD_W'(1);
            3: return COORD_W'(1022);
            default: return COORD_W'($urandom);
         endcase
      end
      return COORD_W'($urandom);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic load_curve(input curve_type pts);
      for (int i = 0; i < NUM_REGS; i++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= reg_idx_type'(i);
         csr_wdata <= pts[i];
         ctrl_pt[i] = pts[i];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      curve_sets++;
   endtask

   task automatic wait_idle();
      while (param_queue.size() != 0 || pixel_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (NUM_STG + 2) @(posedge clock);
   endtask

   // request driver: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap   = 0;
         send_burst = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            pixel_queue.push_back(bezier_pixel(req_ch.curve_param));
            void'(param_queue.pop_front());
            params_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (param_queue.size() > 0) begin
               req_ch.valid       <= 1'b1;
               req_ch.curve_param <= param_queue[0];
               if (send_burst > 0) begin
                  send_burst--;
               end else begin
                  send_burst = $urandom_range(0, 24);
                  send_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response sink: own stall pattern, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_pos = 0;
         stall_pat = '1;
      end else begin
         if (hold_served != hold_asks) begin
            hold_served = hold_asks;
            hold_left   = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (stall_pos == 0) begin
               stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            end
            rsp_ch.ready <= stall_pat[stall_pos];
            stall_pos = (stall_pos + 1) % 16;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pixel_queue.size() == 0) begin
            $display("[%0t] response transaction with nothing outstanding", $time);
            mismatch_count++;
         end else begin
            want = pixel_queue.pop_front();
            pixels_checked++;
            if (rsp_ch.pixel_x !== want.x) begin
               report_mismatch("pixel_x", rsp_ch.pixel_x, want.x);
            end
            if (rsp_ch.pixel_y !== want.y) begin
               report_mismatch("pixel_y", rsp_ch.pixel_y, want.y);
            end
            if (rsp_ch.inside_res !== want.in_surface) begin
               report_mismatch("inside_res", rsp_ch.inside_res, want.in_surface);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      curve_type pts;
      logic [PARAM_W-1:0] corner_params [11];
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.curve_param = '0;
      rsp_ch.ready       = 1'b0;
      for (int i = 0; i < NUM_REGS; i++) ctrl_pt[i] = '0;
      corner_params = '{16'h0000, 16'h0001, 16'hFFFF, 16'hFFFE, 16'h8000, 16'h4000,
                        16'hC000, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // control points still at their reset value
      param_queue = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001};
      wait_idle();

      for (int i = 0; i < NUM_REGS; i++) pts[i] = '1;
      load_curve(pts);
      param_queue = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001};
      wait_idle();

      for (int i = 0; i < NUM_REGS; i++) pts[i] = ((i / 2) % 2 == i % 2) ? '0 : '1;
      load_curve(pts);
      foreach (corner_params[i]) param_queue.push_back(corner_params[i]);
      wait_idle();

      for (int s = 0; s < RAND_SETS; s++) begin
         for (int i = 0; i < NUM_REGS; i++) pts[i] = rand_coord(s % 2 == 0);
         load_curve(pts);
         for (int n = 0; n < HALF_SET; n++) param_queue.push_back(rand_param());
         if (s == 1 || s == 4) begin
            hold_asks <= hold_asks + 1;
         end
         wait_idle();
         for (int n = 0; n < HALF_SET; n++) param_queue.push_back(rand_param());
         wait_idle();
      end

      repeat (NUM_STG + 5) @(posedge clock);
      $display("%0d curve parameters sent over %0d control point sets", params_sent,
               curve_sets + 1);
      $display("%0d pixel transactions checked, %0d mismatches", pixels_checked,
               mismatch_count);
      if (mismatch_count == 0 && pixel_queue.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
